// ----- rtl/core/itt_pkg.sv -----
// Shared types and constants for the I2C target transmitter.
package itt_pkg;

    localparam int BUF_DEPTH  = 16;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);
    localparam int ADDR_W     = 7;
    localparam int LEN_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int LOAD_IDX_W = 4;
    localparam int PHASE_W    = 3;
    localparam int BITCNT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [BITCNT_W-1:0] BIT_LAST = BITCNT_W'(8);

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_AACK = 3'd2,
        PH_DATA = 3'd3,
        PH_DACK = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDRESS = 2'd0,
        CFG_TX_LENGTH   = 2'd1
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef struct packed {
        logic               sda_release;
        logic [PHASE_W-1:0] phase_code;
        logic               transfer_done;
        logic               address_matched;
        logic               master_acked;
        logic [LEN_W-1:0]   bytes_sent;
    } result_t;

endpackage

// ----- rtl/core/itt_ifs.sv -----
// Valid/ready channel interfaces for line samples and results.
interface itt_in_if import itt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic                  scl_level;
    logic                  sda_level;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [BYTE_W-1:0]     load_value;

    modport source (output valid, operation, scl_level, sda_level, load_index, load_value,
                    input ready);
    modport sink   (input valid, operation, scl_level, sda_level, load_index, load_value,
                    output ready);
endinterface

interface itt_out_if import itt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               sda_release;
    logic [PHASE_W-1:0] phase_code;
    logic               transfer_done;
    logic               address_matched;
    logic               master_acked;
    logic [LEN_W-1:0]   bytes_sent;

    modport source (output valid, sda_release, phase_code, transfer_done, address_matched,
                    master_acked, bytes_sent, input ready);
    modport sink   (input valid, sda_release, phase_code, transfer_done, address_matched,
                    master_acked, bytes_sent, output ready);
endinterface

// ----- rtl/core/i2c_target_transmitter_top.sv -----
// Result words are registered into the result queue as their sample words are accepted.
// Throughput: one word per cycle while the result queue has room; the line FSM decides
//   combinationally and the buffer RAM is read ahead every cycle, hiding its read register.
// Output: a two-deep result queue; input ready drops only while both entries are full.
// Reset (rst_n, async, active low): line FSM idle, SDA released, SDA history high, other
//   control registers 0; queue data not reset; buffer RAM not cleared, garbage until loaded.
module i2c_target_transmitter_top import itt_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    itt_in_if.sink                sample,
    itt_out_if.source             result
);

    // Configuration registers
    logic [ADDR_W-1:0]   own_address_reg;
    logic [LEN_W-1:0]    tx_length_reg;

    // Line state
    phase_t              phase_reg, phase_next;
    logic                clk_high_reg, clk_high_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [BITCNT_W-1:0] bit_count_reg, bit_count_next;
    logic [LEN_W-1:0]    byte_index_reg, byte_index_next;
    logic                prev_sda_reg, prev_sda_next;
    logic                sda_drive_reg, sda_drive_next;
    logic                master_ack_reg, master_ack_next;

    // Transmit buffer RAM
    logic [BYTE_W-1:0]   buf_mem [BUF_DEPTH];
    logic [BUF_AW-1:0]   rd_addr;
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                wr_en;
    logic [BUF_AW-1:0]   wr_addr;

    // Result queue: front entry drives the port, skid entry catches one more word
    result_t             front_reg, front_next;
    result_t             skid_reg, skid_next;
    logic                front_valid_reg, front_valid_next;
    logic                skid_valid_reg, skid_valid_next;

    logic                accept;
    logic                is_line;
    logic                pop;
    logic                rise;
    logic                fall;
    logic                done;
    logic                matched;
    logic [LEN_W-1:0]    eff_len;
    result_t             res;

    assign sample.ready = !skid_valid_reg;
    assign accept       = sample.valid && sample.ready;
    assign is_line      = accept && (sample.operation == OP_SAMPLE);
    assign pop          = front_valid_reg && result.ready;

    // tx_length saturates at the buffer depth
    assign eff_len = (tx_length_reg > LEN_W'(BUF_DEPTH)) ? LEN_W'(BUF_DEPTH) : tx_length_reg;

    // Buffer loads; indexes past the buffer are dropped
    assign wr_en   = accept && (sample.operation == OP_LOAD)
                     && (int'(sample.load_index) < BUF_DEPTH);
    assign wr_addr = sample.load_index[BUF_AW-1:0];

    // Read-ahead address: the byte the next load step would need. A byte is only consumed
    // on an SCL fall in address-ack or data-ack, and the word before such a fall is always
    // an SCL rise, idle time or a buffer load, none of which moves this address. So the
    // registered read data is always the right byte when the fall arrives.
    always_comb
    begin
        if (phase_reg == PH_AACK)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = BUF_AW'(byte_index_reg + 1'b1);
        end
    end

    // RAM with write-first forwarding onto the read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_addr] <= sample.load_value;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= sample.load_value;
        end
        else
        begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

    assign rise = sample.scl_level && !clk_high_reg;
    assign fall = !sample.scl_level && clk_high_reg;

    // Line state machine: one decision per sample word
    always_comb
    begin
        phase_next      = phase_reg;
        clk_high_next   = clk_high_reg;
        shift_next      = shift_reg;
        bit_count_next  = bit_count_reg;
        byte_index_next = byte_index_reg;
        prev_sda_next   = prev_sda_reg;
        sda_drive_next  = sda_drive_reg;
        master_ack_next = master_ack_reg;
        done            = 1'b0;
        matched         = 1'b0;

        if (is_line)
        begin
            prev_sda_next = sample.sda_level;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    // start: SDA falls while SCL high
                    if (sample.scl_level && prev_sda_reg && !sample.sda_level)
                    begin
                        phase_next      = PH_ADDR;
                        clk_high_next   = 1'b1;
                        shift_next      = '0;
                        bit_count_next  = '0;
                        byte_index_next = '0;
                        sda_drive_next  = 1'b1;
                    end
                end
                PH_ADDR:
                begin
                    if (rise)
                    begin
                        clk_high_next  = 1'b1;
                        shift_next     = {shift_reg[BYTE_W-2:0], sample.sda_level};
                        bit_count_next = bit_count_reg + 1'b1;
                    end
                    else if (fall)
                    begin
                        clk_high_next = 1'b0;
                        if (bit_count_reg >= BIT_LAST)
                        begin
                            // R/W bit ignored: compare the upper seven bits only
                            sda_drive_next = (shift_reg[BYTE_W-1:1] == own_address_reg)
                                             ? 1'b0 : 1'b1;
                            phase_next     = PH_AACK;
                        end
                    end
                end
                PH_AACK:
                begin
                    if (rise)
                    begin
                        clk_high_next = 1'b1;
                    end
                    else if (fall)
                    begin
                        clk_high_next  = 1'b0;
                        sda_drive_next = 1'b1;
                        if (!sda_drive_reg && (eff_len != '0))
                        begin
                            byte_index_next = '0;
                            shift_next      = rd_data_reg;
                            bit_count_next  = '0;
                            sda_drive_next  = rd_data_reg[BYTE_W-1];
                            phase_next      = PH_DATA;
                        end
                        else
                        begin
                            done       = 1'b1;
                            matched    = !sda_drive_reg;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (rise)
                    begin
                        clk_high_next = 1'b1;
                    end
                    else if (fall)
                    begin
                        clk_high_next  = 1'b0;
                        bit_count_next = bit_count_reg + 1'b1;
                        shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                        if (bit_count_next >= BIT_LAST)
                        begin
                            sda_drive_next = 1'b1;
                            phase_next     = PH_DACK;
                        end
                        else
                        begin
                            sda_drive_next = shift_reg[BYTE_W-2];
                        end
                    end
                end
                PH_DACK:
                begin
                    if (rise)
                    begin
                        clk_high_next   = 1'b1;
                        master_ack_next = !sample.sda_level;
                    end
                    else if (fall)
                    begin
                        clk_high_next   = 1'b0;
                        byte_index_next = byte_index_reg + 1'b1;
                        if (byte_index_next >= eff_len)
                        begin
                            sda_drive_next = 1'b1;
                            done           = 1'b1;
                            matched        = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            shift_next     = rd_data_reg;
                            bit_count_next = '0;
                            sda_drive_next = rd_data_reg[BYTE_W-1];
                            phase_next     = PH_DATA;
                        end
                    end
                end
                default:
                begin
                    phase_next     = PH_IDLE;
                    sda_drive_next = 1'b1;
                    clk_high_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            tx_length_reg   <= '0;
            phase_reg       <= PH_IDLE;
            clk_high_reg    <= 1'b0;
            shift_reg       <= '0;
            bit_count_reg   <= '0;
            byte_index_reg  <= '0;
            prev_sda_reg    <= 1'b1;
            sda_drive_reg   <= 1'b1;
            master_ack_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_OWN_ADDRESS))
            begin
                own_address_reg <= cfg_data[ADDR_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_TX_LENGTH))
            begin
                tx_length_reg <= cfg_data[LEN_W-1:0];
            end
            phase_reg      <= phase_next;
            clk_high_reg   <= clk_high_next;
            shift_reg      <= shift_next;
            bit_count_reg  <= bit_count_next;
            byte_index_reg <= byte_index_next;
            prev_sda_reg   <= prev_sda_next;
            sda_drive_reg  <= sda_drive_next;
            master_ack_reg <= master_ack_next;
        end
    end

    // Result word: state after this word (loads show the state unchanged)
    assign res = '{sda_release:     sda_drive_next,
                   phase_code:      phase_next,
                   transfer_done:   done,
                   address_matched: matched,
                   master_acked:    master_ack_next,
                   bytes_sent:      byte_index_next};

    // Two-entry queue; a push never meets a full skid because ready is !skid_valid
    always_comb
    begin
        front_next       = front_reg;
        skid_next        = skid_reg;
        front_valid_next = front_valid_reg;
        skid_valid_next  = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                front_next      = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                front_next = res;
            end
            else
            begin
                front_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (front_valid_reg)
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                front_next       = res;
                front_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        skid_reg  <= skid_next;
    end

    assign result.valid           = front_valid_reg;
    assign result.sda_release     = front_reg.sda_release;
    assign result.phase_code      = front_reg.phase_code;
    assign result.transfer_done   = front_reg.transfer_done;
    assign result.address_matched = front_reg.address_matched;
    assign result.master_acked    = front_reg.master_acked;
    assign result.bytes_sent      = front_reg.bytes_sent;

endmodule

// ----- rtl/core/itt_checker.sv -----
// Port-level assertions for the I2C target transmitter, bound to the top level.
module itt_checker import itt_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               sda_release,
    input logic [PHASE_W-1:0] phase_code,
    input logic               transfer_done,
    input logic               address_matched,
    input logic               master_acked,
    input logic [LEN_W-1:0]   bytes_sent
);

    // done always leaves the FSM idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && transfer_done |-> phase_code == PH_IDLE)
        else $error("done word not idle");

    // matched is only reported with done
    a_match_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && address_matched |-> transfer_done)
        else $error("matched without done");

    // SDA is never held low while idle
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase_code == PH_IDLE) |-> sda_release)
        else $error("SDA pulled low in idle");

    // byte count never passes the buffer depth
    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(bytes_sent) <= BUF_DEPTH)
        else $error("bytes_sent past buffer depth");

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sda_release) && $stable(phase_code)
            && $stable(transfer_done) && $stable(address_matched)
            && $stable(master_acked) && $stable(bytes_sent))
        else $error("stalled result word changed");

endmodule

bind i2c_target_transmitter_top itt_checker u_itt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .sda_release     (result.sda_release),
    .phase_code      (result.phase_code),
    .transfer_done   (result.transfer_done),
    .address_matched (result.address_matched),
    .master_acked    (result.master_acked),
    .bytes_sent      (result.bytes_sent)
);
